FILE: hw/rtl/acsc_pkg.sv
// package for the alarm clock set controller
// holds event and mode codes, the state record and the result record; no dependencies
package acsc_pkg;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  localparam logic [HourW-1:0]   LastHour   = HourW'(23);
  localparam logic [MinuteW-1:0] LastMinute = MinuteW'(59);

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [1:0] {
    OpJoy     = 2'd0,
    OpRot     = 2'd1,
    OpTimeout = 2'd2,
    OpTick    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ModeSetHour = 3'd0,
    ModeSetMin  = 3'd1,
    ModeNormal  = 3'd2,
    ModeAlHour  = 3'd3,
    ModeAlMin   = 3'd4,
    ModeRing    = 3'd5
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [HourW-1:0]   edit_hour;
    logic [MinuteW-1:0] edit_minute;
    logic               arm;
    logic [HourW-1:0]   alarm_hour;
    logic [MinuteW-1:0] alarm_minute;
  } state_t;

  typedef struct packed {
    logic [SecondW-1:0] now_second;
    logic [MinuteW-1:0] now_minute;
    logic [HourW-1:0]   now_hour;
  } event_t;

  typedef struct packed {
    logic               clock_load;
    logic [HourW-1:0]   load_hour;
    logic [MinuteW-1:0] load_minute;
  } load_t;

endpackage

FILE: hw/rtl/acsc_next.sv
// next-state logic for one event of the alarm clock set controller
// depends on acsc_pkg
module acsc_next import acsc_pkg::*; (
  input  state_t state_i,
  input  op_e    op_i,
  input  event_t event_i,
  output state_t state_o,
  output load_t  load_o
);

  logic [HourW-1:0]   hour_inc;
  logic [MinuteW-1:0] minute_inc;
  logic               alarm_hit;

  // edit time only ever holds in-range values, so wrap on the last one
  assign hour_inc   = (state_i.edit_hour == LastHour) ? '0 : state_i.edit_hour + HourW'(1);
  assign minute_inc = (state_i.edit_minute == LastMinute) ? '0
                                                          : state_i.edit_minute + MinuteW'(1);

  assign alarm_hit = state_i.arm
                   && (event_i.now_hour == state_i.alarm_hour)
                   && (event_i.now_minute == state_i.alarm_minute)
                   && (event_i.now_second == '0);

  always_comb begin
    state_o = state_i;
    load_o  = '0;
    case (state_i.mode)
      ModeSetHour: begin
        if (op_i == OpJoy) begin
          load_o.clock_load  = 1'b1;
          load_o.load_hour   = state_i.edit_hour;
          load_o.load_minute = state_i.edit_minute;
          state_o.mode       = ModeSetMin;
        end else if (op_i == OpRot) begin
          state_o.edit_hour = hour_inc;
        end
      end
      ModeSetMin: begin
        if (op_i == OpJoy) begin
          load_o.clock_load   = 1'b1;
          load_o.load_hour    = state_i.edit_hour;
          load_o.load_minute  = state_i.edit_minute;
          state_o.edit_hour   = '0;
          state_o.edit_minute = '0;
          state_o.mode        = ModeNormal;
        end else if (op_i == OpRot) begin
          state_o.edit_minute = minute_inc;
        end
      end
      ModeNormal: begin
        if (op_i == OpJoy) begin
          state_o.mode = ModeAlHour;
        end else if (op_i == OpRot) begin
          state_o.arm = ~state_i.arm;
        end else if (op_i == OpTick && alarm_hit) begin
          state_o.mode = ModeRing;
        end
      end
      ModeAlHour: begin
        if (op_i == OpJoy) begin
          state_o.mode = ModeAlMin;
        end else if (op_i == OpRot) begin
          state_o.edit_hour = hour_inc;
        end
      end
      ModeAlMin: begin
        if (op_i == OpJoy) begin
          state_o.alarm_hour   = state_i.edit_hour;
          state_o.alarm_minute = state_i.edit_minute;
          state_o.mode         = ModeNormal;
        end else if (op_i == OpRot) begin
          state_o.edit_minute = minute_inc;
        end
      end
      ModeRing: begin
        if (op_i != OpTick) begin
          state_o.mode = ModeNormal;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/alarm_clock_set_controller_core.sv
// top level of the alarm clock set controller: stream ports, state and result registers
// depends on acsc_pkg and acsc_next
//
// Each accepted event item updates the controller state in the same clock edge and yields
// exactly one result item, held in an output register and shown in the cycle after acceptance.
// The block takes one event per cycle: s_axis_tready stays high while the output register
// is empty or its item is taken in the same cycle, so the output register alone sets the
// rate. Events are joystick press, rotary press, ring timeout and a one-second tick with
// the current time; the ring timeout itself is timed outside the block.
module alarm_clock_set_controller_core import acsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [4:0] now_hour, [10:5] now_minute, [16:11] now_second, rest zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [2:0] mode, [7:3] shown_hour, [13:8] shown_minute, [14] armed, [15] ringing,
  // [16] clock_load, [21:17] load_hour, [27:22] load_minute, rest zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  state_t state_q, state_d;
  load_t  load;
  event_t evt;
  op_e    op;
  logic   accept;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign op  = op_e'(s_axis_tuser_i);
  assign evt = event_t'(s_axis_tdata_i[HourW+MinuteW+SecondW-1:0]);

  acsc_next u_next (
    .state_i (state_q),
    .op_i    (op),
    .event_i (evt),
    .state_o (state_d),
    .load_o  (load)
  );

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  assign out_valid_d = accept | (out_valid_q & ~m_axis_tready_i);
  assign out_data_d  = {4'b0000, load.load_minute, load.load_hour, load.clock_load,
                        (state_d.mode == ModeRing), state_d.arm,
                        state_d.edit_minute, state_d.edit_hour, state_d.mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{mode: ModeSetHour, default: '0};
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ringing flag mirrors the ringing mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[15] == (out_data_q[2:0] == ModeRing)))
    else $error("ringing flag disagrees with mode");

  // load time is zero unless the strobe is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q[16]) |-> (out_data_q[27:17] == '0))
    else $error("load time without strobe");

  // a load strobe only comes from the clock setting modes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && load.clock_load) |->
      (state_q.mode == ModeSetHour || state_q.mode == ModeSetMin))
    else $error("clock load outside clock setting");

  // edit time stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.edit_hour <= LastHour) && (state_q.edit_minute <= LastMinute))
    else $error("edit time out of range");

  // a held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result lost");

endmodule

FILE: test/tb_top.sv
// testbench for alarm_clock_set_controller_core: event items in, status items out
// depends on acsc_pkg and the core; each status item is predicted or scripted and checked field by field
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acsc_pkg::*;

  localparam int unsigned RandomItems = 940;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ScriptRows  = 27;

  typedef struct packed {
    mode_e              mode;
    logic [HourW-1:0]   shown_hour;
    logic [MinuteW-1:0] shown_minute;
    logic               armed;
    logic               ringing;
    logic               clock_load;
    logic [HourW-1:0]   load_hour;
    logic [MinuteW-1:0] load_minute;
  } status_t;

  typedef struct packed {
    op_e                op;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [6:0]         reps;
    logic               typed;
    status_t            want;
  } event_row_t;

  localparam status_t Unchecked = '0;

  // typed status applies to the last repetition of a row only
  localparam event_row_t Script [ScriptRows] = '{
    '{OpTick, 5'd23, 6'd59, 6'd59, 7'd1, 1'b1,
      '{ModeSetHour, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpTimeout, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeSetHour, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd23, 1'b0, Unchecked},
    // hour wraps from 23 to 0
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeSetHour, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd2, 1'b0, Unchecked},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeSetMin, 5'd2, 6'd0, 1'b0, 1'b0, 1'b1, 5'd2, 6'd0}},
    '{OpTick, 5'd31, 6'd63, 6'd63, 7'd1, 1'b0, Unchecked},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd59, 1'b0, Unchecked},
    // minute wraps from 59 to 0
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeSetMin, 5'd2, 6'd0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeNormal, 5'd0, 6'd0, 1'b0, 1'b0, 1'b1, 5'd2, 6'd1}},
    // matching tick while disarmed
    '{OpTick, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeNormal, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeNormal, 5'd0, 6'd0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpTick, 5'd0, 6'd0, 6'd1, 7'd1, 1'b0, Unchecked},
    '{OpTick, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeRing, 5'd0, 6'd0, 1'b1, 1'b1, 1'b0, 5'd0, 6'd0}},
    '{OpTimeout, 5'd0, 6'd0, 6'd0, 7'd1, 1'b1,
      '{ModeNormal, 5'd0, 6'd0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0}},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    // tick outside normal mode never rings
    '{OpTick, 5'd1, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpTimeout, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpTick, 5'd1, 6'd1, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpJoy, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpTick, 5'd1, 6'd1, 6'd0, 7'd1, 1'b0, Unchecked},
    '{OpRot, 5'd0, 6'd0, 6'd0, 7'd1, 1'b0, Unchecked}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                src_valid = 1'b0;
  logic                src_ready;
  logic [InDataW-1:0]  src_data  = '0;
  logic [1:0]          src_op    = '0;
  logic                snk_valid;
  logic                snk_ready = 1'b0;
  logic [OutDataW-1:0] snk_data;

  // predictor copy of the controller state
  mode_e              ctl_mode = ModeSetHour;
  logic [HourW-1:0]   edit_h   = '0;
  logic [MinuteW-1:0] edit_m   = '0;
  logic               arm_q    = 1'b0;
  logic [HourW-1:0]   alarm_h  = '0;
  logic [MinuteW-1:0] alarm_m  = '0;

  status_t     pending_status [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          src_quiet   = 1'b0;
  bit          snk_quiet   = 1'b0;

  alarm_clock_set_controller_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_data),
    .s_axis_tuser_i  (src_op),
    .m_axis_tvalid_o (snk_valid),
    .m_axis_tready_i (snk_ready),
    .m_axis_tdata_o  (snk_data)
  );

  always #1 clk = ~clk;

  function automatic status_t advance_clock(input op_e op, input logic [HourW-1:0] h,
                                            input logic [MinuteW-1:0] m,
                                            input logic [SecondW-1:0] s);
    status_t r;
    r = '0;
    case (ctl_mode)
      ModeSetHour, ModeAlHour: begin
        if (op == OpJoy) begin
          if (ctl_mode == ModeSetHour) begin
            r.clock_load  = 1'b1;
            r.load_hour   = edit_h;
            r.load_minute = edit_m;
            ctl_mode      = ModeSetMin;
          end else begin
            ctl_mode = ModeAlMin;
          end
        end else if (op == OpRot) begin
          edit_h = (edit_h == LastHour) ? '0 : edit_h + HourW'(1);
        end
      end
      ModeSetMin, ModeAlMin: begin
        if (op == OpJoy) begin
          if (ctl_mode == ModeSetMin) begin
            r.clock_load  = 1'b1;
            r.load_hour   = edit_h;
            r.load_minute = edit_m;
            edit_h        = '0;
            edit_m        = '0;
          end else begin
            alarm_h = edit_h;
            alarm_m = edit_m;
          end
          ctl_mode = ModeNormal;
        end else if (op == OpRot) begin
          edit_m = (edit_m == LastMinute) ? '0 : edit_m + MinuteW'(1);
        end
      end
      ModeNormal: begin
        if (op == OpJoy) begin
          ctl_mode = ModeAlHour;
        end else if (op == OpRot) begin
          arm_q = ~arm_q;
        end else if (op == OpTick && arm_q && h == alarm_h && m == alarm_m && s == '0) begin
          ctl_mode = ModeRing;
        end
      end
      ModeRing: begin
        if (op != OpTick) ctl_mode = ModeNormal;
      end
      default: begin
      end
    endcase
    r.mode         = ctl_mode;
    r.shown_hour   = edit_h;
    r.shown_minute = edit_m;
    r.armed        = arm_q;
    r.ringing      = (ctl_mode == ModeRing);
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_event(input op_e op, input logic [HourW-1:0] h,
                            input logic [MinuteW-1:0] m, input logic [SecondW-1:0] s,
                            input bit typed, input status_t want);
    status_t     pred;
    int unsigned gap;
    src_valid <= 1'b1;
    src_op    <= op;
    src_data  <= InDataW'({s, m, h});
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    pred = advance_clock(op, h, m, s);
    pending_status.push_back(typed ? want : pred);
    gap = pick_gap(src_quiet);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (src_valid) src_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic run_random();
    int unsigned        counted;
    int unsigned        r;
    int unsigned        burst;
    op_e                op;
    logic [HourW-1:0]   h;
    logic [MinuteW-1:0] m;
    logic [SecondW-1:0] s;
    counted = 0;
    burst   = 0;
    while (counted < RandomItems) begin
      h = HourW'($urandom_range(0, 31));
      m = MinuteW'($urandom_range(0, 63));
      s = SecondW'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      case (ctl_mode)
        ModeNormal: begin
          if (r < 50) op = OpTick;
          else if (r < 65) op = OpRot;
          else if (r < 85) op = OpJoy;
          else op = OpTimeout;
        end
        ModeAlHour, ModeAlMin: begin
          // long rotary runs walk the edit time through its wrap
          if (burst == 0 && r < 6) burst = $urandom_range(20, 70);
          if (burst != 0) begin
            op = OpRot;
            burst--;
          end else if (r < 60) op = OpRot;
          else if (r < 85) op = OpJoy;
          else op = (r < 93) ? OpTick : OpTimeout;
        end
        ModeRing: begin
          if (r < 25) op = OpTick;
          else if (r < 50) op = OpJoy;
          else if (r < 75) op = OpRot;
          else op = OpTimeout;
        end
        default: op = op_e'($urandom_range(0, 3));
      endcase
      if (op == OpTick) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          h = alarm_h;
          m = alarm_m;
          s = ($urandom_range(0, 3) == 0) ? SecondW'($urandom_range(1, 59)) : '0;
        end else if (r >= 45) begin
          h = HourW'($urandom_range(0, 23));
          m = MinuteW'($urandom_range(0, 59));
          s = SecondW'($urandom_range(0, 59));
        end
      end
      send_event(op, h, m, s, 1'b0, Unchecked);
      counted++;
      if ($urandom_range(0, 59) == 0) src_quiet = ~src_quiet;
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 149) == 0) snk_quiet = ~snk_quiet;
    if (stall_left != 0) begin
      stall_left--;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= 1'b1;
      stall_left = pick_gap(snk_quiet);
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && snk_valid && snk_ready) begin
      got.mode         = mode_e'(snk_data[2:0]);
      got.shown_hour   = snk_data[7:3];
      got.shown_minute = snk_data[13:8];
      got.armed        = snk_data[14];
      got.ringing      = snk_data[15];
      got.clock_load   = snk_data[16];
      got.load_hour    = snk_data[21:17];
      got.load_minute  = snk_data[27:22];
      if (pending_status.size() == 0) begin
        $display("%0t: status item expected none actual %h", $time, snk_data);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("shown_hour", want.shown_hour, got.shown_hour);
        check_field("shown_minute", want.shown_minute, got.shown_minute);
        check_field("armed", want.armed, got.armed);
        check_field("ringing", want.ringing, got.ringing);
        check_field("clock_load", want.clock_load, got.clock_load);
        check_field("load_hour", want.load_hour, got.load_hour);
        check_field("load_minute", want.load_minute, got.load_minute);
      end
    end
  end

  // ends a hung run: no item moved on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((src_valid && src_ready) || (snk_valid && snk_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("tb_top failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (Script[i]) begin
      for (k = 0; k < Script[i].reps; k++) begin
        send_event(Script[i].op, Script[i].hour, Script[i].minute, Script[i].second,
                   Script[i].typed && (k == Script[i].reps - 1), Script[i].want);
      end
    end
    // hold the sender until every status item is back
    wait_drained();
    run_random();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
